### hw/rtl/assert_macros.svh
// Assertion macros shared by the triangle tangent RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define TTU_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// ante implies cons in the same cycle
`define TTU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante implies cons in the next cycle
`define TTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/ttu_pkg.sv
// Types and constants for the triangle tangent unit.
package ttu_pkg;

  localparam int TTU_DW         = 64;
  localparam int TTU_CW         = 6;
  localparam int TTU_SQRT_STEPS = 32;
  localparam int TTU_DIV_STEPS  = 16;
  localparam int TTU_FRAC_SH    = 16;
  localparam int TTU_NORM_BITS  = 30;
  localparam int TTU_OUT_W      = 16;
  localparam logic [TTU_OUT_W-1:0] TTU_Q_MAX = 16'h7FFF;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } ttu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DET0,
    S_DET1,
    S_T0,
    S_T1,
    S_CHK,
    S_SHIFT,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_OUT
  } ttu_state_t;

  typedef struct packed {
    logic    start;
    ttu_op_t op;
  } ttu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ttu_rsp_t;

endpackage

### hw/rtl/ttu_iter.sv
// Bit-serial shared unit: wrapped multiply, integer square root, restoring divide.
`include "assert_macros.svh"
module ttu_iter #(
  parameter int MUL_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ttu_pkg::ttu_req_t       req,
  input  logic [ttu_pkg::TTU_DW-1:0] opa,
  input  logic [ttu_pkg::TTU_DW-1:0] opb,
  output ttu_pkg::ttu_rsp_t       rsp,
  output logic [ttu_pkg::TTU_DW-1:0] result
);
  import ttu_pkg::*;

  logic            busy_r, busy_nxt, done_r, done_nxt;
  ttu_op_t         op_r, op_nxt;
  logic [TTU_CW-1:0] cnt_r, cnt_nxt;
  logic [TTU_DW-1:0] acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [TTU_DW-1:0] x, y;
  logic            sub, borrow;
  logic [TTU_DW:0] sum;

  always_comb begin
    x   = acc_r;
    y   = a_r;
    sub = 1'b0;
    unique case (op_r)
      OP_MUL: begin
        y   = a_r;
        sub = (cnt_r == '0);
      end
      OP_SQRT: begin
        y   = b_r + c_r;
        sub = 1'b1;
      end
      OP_DIV: begin
        x   = {acc_r[TTU_DW-2:0], c_r[TTU_DIV_STEPS-1]};
        y   = b_r;
        sub = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
    sum    = sub ? ({1'b0, x} - {1'b0, y}) : ({1'b0, x} + {1'b0, y});
    borrow = sub & sum[TTU_DW];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      unique case (req.op)
        OP_MUL: begin
          acc_nxt = '0;
          a_nxt   = opa;
          b_nxt   = opb;
          c_nxt   = '0;
          cnt_nxt = TTU_CW'(MUL_BITS - 1);
        end
        OP_SQRT: begin
          acc_nxt = opa;
          a_nxt   = '0;
          b_nxt   = '0;
          c_nxt   = TTU_DW'(1) << (2 * TTU_SQRT_STEPS - 2);
          cnt_nxt = TTU_CW'(TTU_SQRT_STEPS - 1);
        end
        OP_DIV: begin
          acc_nxt = opa >> TTU_DIV_STEPS;
          a_nxt   = '0;
          b_nxt   = opb;
          c_nxt   = {{(TTU_DW-TTU_DIV_STEPS){1'b0}}, opa[TTU_DIV_STEPS-1:0]};
          cnt_nxt = TTU_CW'(TTU_DIV_STEPS - 1);
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      unique case (op_r)
        OP_MUL: begin
          if (b_r[0]) acc_nxt = sum[TTU_DW-1:0];
          a_nxt = a_r << 1;
          b_nxt = b_r >> 1;
        end
        OP_SQRT: begin
          if (!borrow) begin
            acc_nxt = sum[TTU_DW-1:0];
            b_nxt   = (b_r >> 1) + c_r;
          end else begin
            b_nxt   = b_r >> 1;
          end
          c_nxt = c_r >> 2;
        end
        OP_DIV: begin
          acc_nxt = borrow ? x : sum[TTU_DW-1:0];
          a_nxt   = {a_r[TTU_DW-2:0], ~borrow};
          c_nxt   = c_r << 1;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
  end

  always_comb begin
    unique case (op_r)
      OP_MUL:  result = acc_r;
      OP_SQRT: result = b_r;
      OP_DIV:  result = a_r;
      default: result = acc_r;
    endcase
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

  `TTU_ASSERT_IMPLY(a_start_idle, clk, rst_n, req.start, !busy_r)
  `TTU_ASSERT_IMPLY(a_done_idle, clk, rst_n, done_r, !busy_r)
  `TTU_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r && !req.start, !done_r)

endmodule

### hw/rtl/triangle_tangent_unit_core.sv
// Triangle tangent unit top level: corner capture, sequencer and result register.
// Input stream carries one triangle corner per word (position and texture
// coordinate); every third accepted word closes a triangle and yields one
// output word with the Q1.15 unit tangent, plus a degenerate flag in tuser.
// Words one and two of a triangle are only captured. The third word
// starts a sequence on the bit-serial shared unit: 11 multiplies, a
// normalising shift, a square root and three divides before out_tvalid;
// degenerate triangles end after the 8 determinant and edge multiplies.
// in_tready is low throughout. The result sits in an output register;
// the next triangle's corners are accepted while it waits, and a new
// result waits in the sequencer until the register is taken by the
// receiver.
// Reset (rst_n low, synchronous) clears the corner count, the sequencer and
// the output valid; held corners are not cleared.
`include "assert_macros.svh"
module triangle_tangent_unit_core #(
  parameter int POS_WIDTH = 32,
  parameter int UV_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
  input  logic [((3*POS_WIDTH+2*UV_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // tangent_x, tangent_y, tangent_z
  output logic [3*ttu_pkg::TTU_OUT_W-1:0] out_tdata,
  // degenerate
  output logic [0:0] out_tuser
);
  import ttu_pkg::*;

  localparam int MUL_BITS = (UV_WIDTH + 1 > 31) ? UV_WIDTH + 1 : 31;
  localparam int U0 = 3 * POS_WIDTH;
  localparam int U1 = 3 * POS_WIDTH + UV_WIDTH;

  ttu_state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic       issued_r, issued_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  logic [POS_WIDTH-1:0] pa_r [3];
  logic [POS_WIDTH-1:0] pb_r [3];
  logic [POS_WIDTH-1:0] pc_r [3];
  logic [UV_WIDTH-1:0]  uva_r [2];
  logic [UV_WIDTH-1:0]  uvb_r [2];
  logic [UV_WIDTH-1:0]  uvc_r [2];

  logic [TTU_DW-1:0] p0_r, p0_nxt, det_r, det_nxt, l2_r, l2_nxt;
  logic [TTU_DW-1:0] t_r [3];
  logic [TTU_DW-1:0] t_nxt [3];
  logic [TTU_DW-1:0] mag_r [3];
  logic [TTU_DW-1:0] mag_nxt [3];
  logic [31:0]       len_r, len_nxt;
  logic [TTU_OUT_W-1:0] tq_r [3];
  logic [TTU_OUT_W-1:0] tq_nxt [3];
  logic              degen_r, degen_nxt;
  logic [3*TTU_OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic              out_tuser_r, out_tuser_nxt;

  ttu_req_t          req;
  ttu_rsp_t          rsp;
  logic [TTU_DW-1:0] opa, opb, res, tv;
  logic [TTU_DW-1:0] dab0, dab1, dac0, dac1, ab, ac;
  logic [TTU_OUT_W-1:0] qs;
  logic              in_acc, big;

  function automatic logic [TTU_DW-1:0] sx_p(input logic [POS_WIDTH-1:0] v);
    return {{(TTU_DW-POS_WIDTH){v[POS_WIDTH-1]}}, v};
  endfunction

  function automatic logic [TTU_DW-1:0] sx_u(input logic [UV_WIDTH-1:0] v);
    return {{(TTU_DW-UV_WIDTH){v[UV_WIDTH-1]}}, v};
  endfunction

  ttu_iter #(.MUL_BITS(MUL_BITS)) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .rsp    (rsp),
    .result (res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  assign dab0 = sx_u(uvb_r[0]) - sx_u(uva_r[0]);
  assign dab1 = sx_u(uvb_r[1]) - sx_u(uva_r[1]);
  assign dac0 = sx_u(uvc_r[0]) - sx_u(uva_r[0]);
  assign dac1 = sx_u(uvc_r[1]) - sx_u(uva_r[1]);
  assign ab   = sx_p(pb_r[idx_r]) - sx_p(pa_r[idx_r]);
  assign ac   = sx_p(pc_r[idx_r]) - sx_p(pa_r[idx_r]);
  assign big  = (|mag_r[0][TTU_DW-1:TTU_NORM_BITS]) | (|mag_r[1][TTU_DW-1:TTU_NORM_BITS])
              | (|mag_r[2][TTU_DW-1:TTU_NORM_BITS]);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    issued_nxt     = issued_r;
    out_tvalid_nxt = out_tvalid_r;
    p0_nxt         = p0_r;
    det_nxt        = det_r;
    l2_nxt         = l2_r;
    len_nxt        = len_r;
    degen_nxt      = degen_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    t_nxt          = t_r;
    mag_nxt        = mag_r;
    tq_nxt         = tq_r;
    req.start      = 1'b0;
    req.op         = OP_MUL;
    opa            = '0;
    opb            = '0;
    tv             = p0_r - res;
    qs             = (res > TTU_DW'(TTU_Q_MAX)) ? TTU_Q_MAX : res[TTU_OUT_W-1:0];

    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;

    if (det_r[TTU_DW-1]) tv = res - p0_r;

    unique case (state_r)
      S_DET0, S_DET1, S_T0, S_T1, S_SQ, S_SQRT, S_DIV: begin
        if (!issued_r) begin
          req.start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (rsp.done) begin
          issued_nxt = 1'b0;
        end
      end
      default: begin
        issued_nxt = 1'b0;
      end
    endcase

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_r == 2'd0 || cnt_r == 2'd1) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_DET0;
          end
        end
      end
      S_DET0: begin
        opa = dab0;
        opb = dac1;
        if (issued_r && rsp.done) begin
          p0_nxt    = res;
          state_nxt = S_DET1;
        end
      end
      S_DET1: begin
        opa = dac0;
        opb = dab1;
        if (issued_r && rsp.done) begin
          det_nxt   = p0_r - res;
          idx_nxt   = '0;
          state_nxt = S_T0;
        end
      end
      S_T0: begin
        opa = ab;
        opb = dac1;
        if (issued_r && rsp.done) begin
          p0_nxt    = res;
          state_nxt = S_T1;
        end
      end
      S_T1: begin
        opa = ac;
        opb = dab1;
        if (issued_r && rsp.done) begin
          t_nxt[idx_r] = tv;
          if (idx_r == 2'd2) begin
            idx_nxt   = '0;
            state_nxt = S_CHK;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_T0;
          end
        end
      end
      S_CHK: begin
        if (det_r == '0 || (t_r[0] == '0 && t_r[1] == '0 && t_r[2] == '0)) begin
          tq_nxt[0] = '0;
          tq_nxt[1] = '0;
          tq_nxt[2] = '0;
          degen_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          for (int i = 0; i < 3; i++) begin
            mag_nxt[i] = t_r[i][TTU_DW-1] ? ('0 - t_r[i]) : t_r[i];
          end
          l2_nxt    = '0;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        opa = mag_r[idx_r];
        opb = mag_r[idx_r];
        if (issued_r && rsp.done) begin
          l2_nxt = l2_r + res;
          if (idx_r == 2'd2) begin
            idx_nxt   = '0;
            state_nxt = S_SQRT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      S_SQRT: begin
        req.op = OP_SQRT;
        opa    = l2_r;
        if (issued_r && rsp.done) begin
          len_nxt   = (res[31:0] == '0) ? 32'd1 : res[31:0];
          idx_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        req.op = OP_DIV;
        opa    = {mag_r[idx_r][TTU_DW-TTU_FRAC_SH-1:0], {TTU_FRAC_SH{1'b0}}}
               + {{(TTU_DW-32){1'b0}}, len_r};
        opb    = {{(TTU_DW-33){1'b0}}, len_r, 1'b0};
        if (issued_r && rsp.done) begin
          tq_nxt[idx_r] = t_r[idx_r][TTU_DW-1] ? ('0 - qs) : qs;
          if (idx_r == 2'd2) begin
            idx_nxt   = '0;
            degen_nxt = 1'b0;
            state_nxt = S_OUT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {tq_r[2], tq_r[1], tq_r[0]};
          out_tuser_nxt  = degen_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      issued_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      issued_r     <= issued_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      unique case (cnt_r)
        2'd0: begin
          pa_r[0]  <= in_tdata[POS_WIDTH-1:0];
          pa_r[1]  <= in_tdata[2*POS_WIDTH-1:POS_WIDTH];
          pa_r[2]  <= in_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
          uva_r[0] <= in_tdata[U1-1:U0];
          uva_r[1] <= in_tdata[U1+UV_WIDTH-1:U1];
        end
        2'd1: begin
          pb_r[0]  <= in_tdata[POS_WIDTH-1:0];
          pb_r[1]  <= in_tdata[2*POS_WIDTH-1:POS_WIDTH];
          pb_r[2]  <= in_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
          uvb_r[0] <= in_tdata[U1-1:U0];
          uvb_r[1] <= in_tdata[U1+UV_WIDTH-1:U1];
        end
        default: begin
          pc_r[0]  <= in_tdata[POS_WIDTH-1:0];
          pc_r[1]  <= in_tdata[2*POS_WIDTH-1:POS_WIDTH];
          pc_r[2]  <= in_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
          uvc_r[0] <= in_tdata[U1-1:U0];
          uvc_r[1] <= in_tdata[U1+UV_WIDTH-1:U1];
        end
      endcase
    end
    p0_r        <= p0_nxt;
    det_r       <= det_nxt;
    l2_r        <= l2_nxt;
    len_r       <= len_nxt;
    degen_r     <= degen_nxt;
    t_r         <= t_nxt;
    mag_r       <= mag_nxt;
    tq_r        <= tq_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `TTU_ASSERT_IMPLY(a_degen_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)
  `TTU_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r != 2'd3)
  `TTU_ASSERT_IMPLY(a_start_busy, clk, rst_n, req.start, state_r != S_IDLE)

endmodule

### dv/triangle_tangent_unit_core_test.sv
// Testbench for the triangle tangent unit: directed and random corners checked by a predictor.
module triangle_tangent_unit_core_test;
  import ttu_pkg::*;

  localparam int PW = 32;
  localparam int UW = 16;
  localparam int DW = ((3*PW+2*UW+7)/8)*8;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [15:0] tz;
    logic [15:0] ty;
    logic [15:0] tx;
    logic        degen;
  } tangent_t;

  typedef struct {
    logic signed [PW-1:0] px, py, pz;
    logic signed [UW-1:0] u, v;
  } corner_t;

  typedef struct {
    corner_t c;
    logic    known;
    logic    degen;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0] out_tuser;

  triangle_tangent_unit_core #(.POS_WIDTH(PW), .UV_WIDTH(UW)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tangent_t pending_tangents[$];
  corner_t held_corners[2];
  int corners_held = 0;
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  logic checked_degen_only = 1'b0;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic tangent_t tangent_of(corner_t a, corner_t b, corner_t c);
    tangent_t res;
    longint dab_u, dab_v, dac_u, dac_v, det, ab, ac;
    longint tv[3];
    longint unsigned mag[3], m, l2, len, q;
    longint pa[3], pb[3], pc[3];
    int s;
    pa = '{a.px, a.py, a.pz};
    pb = '{b.px, b.py, b.pz};
    pc = '{c.px, c.py, c.pz};
    dab_u = longint'(b.u) - a.u;
    dab_v = longint'(b.v) - a.v;
    dac_u = longint'(c.u) - a.u;
    dac_v = longint'(c.v) - a.v;
    det = dab_u * dac_v - dac_u * dab_v;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      ab = pb[i] - pa[i];
      ac = pc[i] - pa[i];
      tv[i] = ab * dac_v - ac * dab_v;
      if (det < 0) tv[i] = -tv[i];
      mag[i] = (tv[i] < 0) ? longint'(-tv[i]) : tv[i];
      if (mag[i] > m) m = mag[i];
    end
    res = '0;
    if (det == 0 || m == 0) begin
      res.degen = 1'b1;
      return res;
    end
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= s;
      l2 += mag[i] * mag[i];
    end
    len = isqrt64(l2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 65536 + len) / (2 * len);
      if (q > 32767) q = 32767;
      if (tv[i] < 0) q = -q;
      case (i)
        0: res.tx = q[15:0];
        1: res.ty = q[15:0];
        default: res.tz = q[15:0];
      endcase
    end
    return res;
  endfunction

  function automatic void note_corner(corner_t c);
    if (corners_held < 2) begin
      held_corners[corners_held] = c;
      corners_held++;
    end else begin
      pending_tangents = {pending_tangents, tangent_of(held_corners[0], held_corners[1], c)};
      corners_held = 0;
    end
  endfunction

  function automatic corner_t rand_corner(int kind);
    corner_t c;
    c.px = $urandom; c.py = $urandom; c.pz = $urandom;
    c.u = 16'($urandom); c.v = 16'($urandom);
    if (kind == 1) begin
      c.px = 32'($signed(16'($urandom))) <<< 8;
      c.py = 32'($signed(16'($urandom))) <<< 8;
      c.pz = 32'($signed(16'($urandom))) <<< 8;
      c.u = 16'($signed(12'($urandom)));
      c.v = 16'($signed(12'($urandom)));
    end else if (kind == 2) begin
      c.u = $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
      c.v = $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
      c.px = $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
    end
    return c;
  endfunction

  // drive one word, wait for acceptance; returns at the following falling edge
  task automatic send_word(corner_t c, int idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {c.v, c.u, c.pz, c.py, c.px};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    note_corner(c);
    @(negedge clk);
  endtask

  task automatic drain(int tail);
    in_tvalid <= 1'b0;
    while (pending_tangents.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    tangent_t exp_t, got;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[47:32], out_tdata[31:16], out_tdata[15:0], out_tuser[0]};
      if (pending_tangents.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h deg=%b", out_tdata, out_tuser);
      end else begin
        exp_t = pending_tangents.pop_front();
        if (checked_degen_only && exp_t.degen != got.degen) mismatches++;
        if (got != exp_t) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tangent mismatch exp x=%h y=%h z=%h d=%b got x=%h y=%h z=%h d=%b",
                     exp_t.tx, exp_t.ty, exp_t.tz, exp_t.degen,
                     got.tx, got.ty, got.tz, got.degen);
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  row_t directed[$];

  task automatic add_row(corner_t c, logic known, logic degen);
    row_t r;
    r.c = c; r.known = known; r.degen = degen;
    directed = {directed, r};
  endtask

  initial begin
    corner_t z, c1, c2;
    int idle_set[4] = '{0, 51, 0, 18};
    int stall_set[4] = '{0, 0, 51, 18};
    z = '{px: 0, py: 0, pz: 0, u: 0, v: 0};
    // all-zero triangle: degenerate
    add_row(z, 0, 0); add_row(z, 0, 0); add_row(z, 1, 1);
    // unit right triangle
    c1 = '{px: 32'sh10000, py: 0, pz: 0, u: 16'sh1000, v: 0};
    c2 = '{px: 0, py: 32'sh10000, pz: 0, u: 0, v: 16'sh1000};
    add_row(z, 0, 0); add_row(c1, 0, 0); add_row(c2, 0, 0);
    // flipped uv winding: negative det
    c2.v = -16'sh1000;
    add_row(z, 0, 0); add_row(c1, 0, 0); add_row(c2, 0, 0);
    // collinear uv: zero det
    c2 = '{px: 32'sh30000, py: 32'sh5, pz: 0, u: 16'sh2000, v: 0};
    add_row(z, 0, 0); add_row(c1, 0, 0); add_row(c2, 1, 1);
    // zero tangent with nonzero det: all positions equal
    c1 = '{px: 0, py: 0, pz: 0, u: 16'sh1000, v: 0};
    c2 = '{px: 0, py: 0, pz: 0, u: 0, v: 16'sh1000};
    add_row(z, 0, 0); add_row(c1, 0, 0); add_row(c2, 1, 1);
    // position and uv extremes
    c1 = '{px: 32'sh7FFFFFFF, py: 32'sh80000000, pz: 32'sh7FFFFFFF,
           u: 16'sh7FFF, v: 16'sh8000};
    c2 = '{px: 32'sh80000000, py: 32'sh7FFFFFFF, pz: 32'sh80000000,
           u: 16'sh8000, v: 16'sh7FFF};
    z = '{px: 32'sh80000000, py: 32'sh80000000, pz: 32'sh80000000,
          u: 16'sh8000, v: 16'sh8000};
    add_row(z, 0, 0); add_row(c1, 0, 0); add_row(c2, 0, 0);
    add_row(c1, 0, 0); add_row(z, 0, 0); add_row(c2, 0, 0);
    c1 = '{px: -1, py: -1, pz: -1, u: -1, v: -1};
    add_row(c1, 0, 0); add_row(c2, 0, 0); add_row(z, 0, 0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].c, 0);
      if (directed[i].known && pending_tangents[$].degen !== directed[i].degen) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d: degenerate not predicted", i);
      end
    end
    drain(20);

    // random, four idling phases; each triangle is three corners
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_set[ph];
      recv_stall = stall_set[ph];
      for (int t = 0; t < 35; t++) begin
        int k;
        k = $urandom_range(9, 0);
        for (int j = 0; j < 3; j++)
          send_word(rand_corner(k < 6 ? 0 : (k < 9 ? 1 : 2)), send_idle);
      end
      drain(20);
    end

    // long receiver hold-off while corners keep coming
    recv_stall = 0;
    hold_off = 3000;
    for (int j = 0; j < 12; j++) send_word(rand_corner(0), 0);
    drain(600);
    recv_stall = 30;
    for (int j = 0; j < 18; j++) send_word(rand_corner(1), 20);
    drain(600);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
